// ===== rtl/hashed_hue_shift_colour_assert.svh =====
// assertion macros shared by the rtl
`ifndef HASHED_HUE_SHIFT_COLOUR_ASSERT_SVH
`define HASHED_HUE_SHIFT_COLOUR_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define HHSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define HHSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/hhsc_pkg.sv =====
`default_nettype none
package hhsc_pkg;
   localparam logic [63:0] HashMult = 64'h9E3779B97F4A7C15;
   // 2^48, 2^32 and 2^16 reduced mod 10000
   localparam logic [12:0] Fold48 = 13'd656;
   localparam logic [12:0] Fold32 = 13'd7296;
   localparam logic [12:0] Fold16 = 13'd5536;
   localparam logic [13:0] HashMod = 14'd10000;
   // floor(x / 10000) = ((x >> 4) * ModRecip) >> 36, exact for x below 2^30
   localparam logic [26:0] ModRecip = 27'd109951163;
   // offset + 4588 = floor((q * 14336 + 7500) / 15625), divide by reciprocal >> 42
   localparam logic [13:0] ShiftMul = 14'd14336;
   localparam logic [12:0] ShiftAdd = 13'd7500;
   localparam logic [28:0] ShiftRecip = 29'd281474977;
   localparam logic [15:0] FloorOff = 16'd4588;

   typedef logic [23:0] rgb_type;

   function automatic rgb_type base_rgb(input logic [2:0] cat);
      rgb_type c;
      case (cat)
         3'd0: c = 24'h7FB2FF;
         3'd1: c = 24'hFFC46B;
         3'd2: c = 24'hFF7A6B;
         3'd3: c = 24'hB98CFF;
         3'd4: c = 24'h7FE0A8;
         default: c = 24'hCFCFCF;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] tier_alpha(input logic [1:0] p);
      logic [7:0] a;
      case (p)
         2'd1: a = 8'hB0;
         2'd2: a = 8'h60;
         default: a = 8'hE0;
      endcase
      return a;
   endfunction

   function automatic logic [7:0] max_chan(input rgb_type c);
      logic [7:0] m;
      m = (c[23:16] > c[15:8]) ? c[23:16] : c[15:8];
      if (c[7:0] > m) m = c[7:0];
      return m;
   endfunction

   function automatic logic [7:0] min_chan(input rgb_type c);
      logic [7:0] m;
      m = (c[23:16] < c[15:8]) ? c[23:16] : c[15:8];
      if (c[7:0] < m) m = c[7:0];
      return m;
   endfunction

   // base hue in q0.16 turns of each palette colour, worked out once
   function automatic logic [15:0] base_hue(input logic [2:0] cat);
      logic [15:0] h;
      case (cat)
         3'd0: h = 16'((64'd461 << 16) / 64'd768);
         3'd1: h = 16'((64'd89 << 16) / 64'd888);
         3'd2: h = 16'((64'd15 << 16) / 64'd888);
         3'd3: h = 16'((64'd505 << 16) / 64'd690);
         3'd4: h = 16'(((64'd41 + 64'd194) << 16) / 64'd582);
         default: h = 16'd0;
      endcase
      return h;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/hashed_hue_shift_colour.sv =====
// a start beat taken at a clock edge shows its rsp_valid strobe after passing through
// 13 register stages (hash product, mod 10000, offset, hue, ramp)
// throughput: one item per cycle, busy is tied low
// the receiver cannot stall, so the pipeline always advances
// reset clears every stage valid bit; payload registers are not reset
`default_nettype none
`include "hashed_hue_shift_colour_assert.svh"
module hashed_hue_shift_colour (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_link_id,
   input  wire logic [2:0]  req_link_category,
   input  wire logic [1:0]  req_prominence,
   output logic             rsp_valid,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha
);
   localparam int Stages = 13;

   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] vld_in;
   // per-stage side data: zero flag, category, alpha
   logic [Stages-1:0] zero_ff;
   logic [2:0]        cat_ff [Stages];
   logic [7:0]        alp_ff [Stages];

   // hash: 64x64 low product in 32-bit partial products
   logic [31:0] id_lo_ff, id_hi_ff;
   logic [63:0] pll_ff;
   logic [31:0] plh_ff, phl_ff;
   logic [63:0] prod_ff;
   // mod 10000: fold 16-bit chunks, then reciprocal quotient
   logic [25:0] m3_ff;
   logic [28:0] m2_ff, m1_ff;
   logic [15:0] m0_ff;
   logic [29:0] fold_ff;
   logic [16:0] quot_ff;
   logic [13:0] fold_lo_ff;
   logic [13:0] q_ff;
   logic [27:0] num_ff;
   logic [13:0] sraw_ff;
   logic [15:0] h_ff;
   logic [18:0] t_ff;
   logic [16:0] w_ff;
   logic [2:0]  sec_ff, sec2_ff;
   logic [7:0]  ramp_ff;

   logic [52:0] quot_full;
   logic [56:0] sraw_full;
   logic [7:0]  mn11, d11;
   logic [23:0] dw;
   logic [7:0]  mx_o, mn_o;
   logic [7:0]  r_o, g_o, b_o;
   hhsc_pkg::rgb_type zb;

   assign busy = 1'b0;
   assign vld_in = {vld_ff[Stages-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff[0] <= (req_link_id == 64'd0);
      cat_ff[0]  <= req_link_category;
      alp_ff[0]  <= hhsc_pkg::tier_alpha(req_prominence);
      for (int i = 1; i < Stages; i++) begin
         zero_ff[i] <= zero_ff[i-1];
         cat_ff[i]  <= cat_ff[i-1];
         alp_ff[i]  <= alp_ff[i-1];
      end
   end

   always_comb begin
      quot_full = 53'(fold_ff[29:4]) * 53'(hhsc_pkg::ModRecip);
      sraw_full = 57'(num_ff) * 57'(hhsc_pkg::ShiftRecip);
      mn11 = hhsc_pkg::min_chan(hhsc_pkg::base_rgb(cat_ff[11]));
      d11  = hhsc_pkg::max_chan(hhsc_pkg::base_rgb(cat_ff[11])) - mn11;
      dw   = 24'(d11) * 24'(w_ff);
   end

   always_ff @(posedge clock) begin
      // s0: split id
      id_lo_ff <= req_link_id[31:0];
      id_hi_ff <= req_link_id[63:32];
      // s1: partial products
      pll_ff <= 64'(id_lo_ff) * 64'(hhsc_pkg::HashMult[31:0]);
      plh_ff <= 32'(id_lo_ff * hhsc_pkg::HashMult[63:32]);
      phl_ff <= 32'(id_hi_ff * hhsc_pkg::HashMult[31:0]);
      // s2: product low 64 bits
      prod_ff <= pll_ff + {32'(plh_ff + phl_ff), 32'd0};
      // s3: chunk weights mod 10000
      m3_ff <= 26'(prod_ff[63:48]) * 26'(hhsc_pkg::Fold48);
      m2_ff <= 29'(prod_ff[47:32]) * 29'(hhsc_pkg::Fold32);
      m1_ff <= 29'(prod_ff[31:16]) * 29'(hhsc_pkg::Fold16);
      m0_ff <= prod_ff[15:0];
      // s4: folded value, congruent mod 10000 and below 2^30
      fold_ff <= 30'(m3_ff) + 30'(m2_ff) + 30'(m1_ff) + 30'(m0_ff);
      // s5: exact quotient by 10000
      quot_ff    <= quot_full[52:36];
      fold_lo_ff <= fold_ff[13:0];
      // s6: remainder fits 14 bits, so low bits are enough
      q_ff <= fold_lo_ff - 14'(quot_ff[13:0] * hhsc_pkg::HashMod);
      // s7: scaled offset numerator
      num_ff <= 28'(q_ff) * 28'(hhsc_pkg::ShiftMul) + 28'(hhsc_pkg::ShiftAdd);
      // s8: offset plus 4588
      sraw_ff <= sraw_full[55:42];
      // s9: rotated hue, wraps at one turn
      h_ff <= hhsc_pkg::base_hue(cat_ff[8]) + 16'(sraw_ff) - hhsc_pkg::FloorOff;
      // s10: sector and fraction
      t_ff <= 19'(h_ff) * 19'd6;
      // s11: ramp factor, full scale in odd sectors when the fraction is zero
      w_ff   <= t_ff[16] ? 17'h10000 - 17'(t_ff[15:0]) : 17'(t_ff[15:0]);
      sec_ff <= t_ff[18:16];
      // s12: ramp channel
      ramp_ff <= mn11 + dw[23:16];
      sec2_ff <= sec_ff;
   end

   always_comb begin
      mx_o = hhsc_pkg::max_chan(hhsc_pkg::base_rgb(cat_ff[Stages-1]));
      mn_o = hhsc_pkg::min_chan(hhsc_pkg::base_rgb(cat_ff[Stages-1]));
      case (sec2_ff)
         3'd0: begin r_o = mx_o;    g_o = ramp_ff; b_o = mn_o;    end
         3'd1: begin r_o = ramp_ff; g_o = mx_o;    b_o = mn_o;    end
         3'd2: begin r_o = mn_o;    g_o = mx_o;    b_o = ramp_ff; end
         3'd3: begin r_o = mn_o;    g_o = ramp_ff; b_o = mx_o;    end
         3'd4: begin r_o = ramp_ff; g_o = mn_o;    b_o = mx_o;    end
         default: begin r_o = mx_o; g_o = mn_o; b_o = ramp_ff; end
      endcase
   end

   assign zb = hhsc_pkg::base_rgb(cat_ff[Stages-1]);

   assign rsp_valid = vld_ff[Stages-1];
   assign rsp_red   = zero_ff[Stages-1] ? zb[23:16] : r_o;
   assign rsp_green = zero_ff[Stages-1] ? zb[15:8]  : g_o;
   assign rsp_blue  = zero_ff[Stages-1] ? zb[7:0]   : b_o;
   assign rsp_alpha = alp_ff[Stages-1];

   `HHSC_ASSERT_IMP(a_never_busy, clock, reset, 1'b1, !busy)
   `HHSC_ASSERT_NEXT(a_start_tracks, clock, reset, start, vld_ff[0])
   `HHSC_ASSERT_IMP(a_ramp_range, clock, reset, rsp_valid && !zero_ff[Stages-1], (ramp_ff <= mx_o) && (ramp_ff >= mn_o))
endmodule
`default_nettype wire
